// ===== design/gaps_pkg.sv =====
package gaps_pkg;

	localparam int POP_MAX_DEF   = 64;
	localparam int MAX_DRAWS_DEF = 8;

	localparam int SLOT_W     = 6;
	localparam int FIT_W      = 32;
	localparam int UNI_W      = 32;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 7;

	localparam logic [CFG_IDX_W-1:0] REG_METHOD   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MINIMIZE = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TOUR     = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_POP      = 4'd3;

	localparam logic [1:0] METHOD_TOUR = 2'd0;
	localparam logic [1:0] METHOD_ROUL = 2'd1;
	localparam logic [1:0] METHOD_RANK = 2'd2;

	localparam logic [2:0] OP_NONE  = 3'd0;
	localparam logic [2:0] OP_TOUR  = 3'd1;
	localparam logic [2:0] OP_WORST = 3'd2;
	localparam logic [2:0] OP_TOTAL = 3'd3;
	localparam logic [2:0] OP_CUM   = 3'd4;
	localparam logic [2:0] OP_FI    = 3'd5;
	localparam logic [2:0] OP_CNT   = 3'd6;
	localparam logic [2:0] OP_RANK  = 3'd7;

	localparam logic [1:0] ASEL_IDX  = 2'd0;
	localparam logic [1:0] ASEL_DRAW = 2'd1;
	localparam logic [1:0] ASEL_I    = 2'd2;

	typedef struct packed {
		logic [2:0] op;
		logic [1:0] asel;
		logic       mul_clr;
		logic       mul_step;
		logic       chk;
		logic       rk_tot;
		logic       rk_tgt;
		logic       scan;
		logic       rk_wr;
		logic       clr_stale;
		logic       emit;
		logic       idle;
	} cmd_t;

	typedef struct packed {
		logic       sel_start;
		logic       stale;
		logic [1:0] method;
		logic       tot_pos;
		logic       hit;
		logic       out_busy;
	} sts_t;

endpackage

// ===== design/gaps_if.sv =====
interface gaps_item_if;
	logic                              valid;
	logic                              ready;
	logic                              mode;
	logic [gaps_pkg::SLOT_W-1:0]       slot;
	logic signed [gaps_pkg::FIT_W-1:0] fitness_value;
	logic [gaps_pkg::UNI_W-1:0]        uniform;
	logic [gaps_pkg::SLOT_W-1:0]       draw0;
	logic [gaps_pkg::SLOT_W-1:0]       draw1;
	logic [gaps_pkg::SLOT_W-1:0]       draw2;
	logic [gaps_pkg::SLOT_W-1:0]       draw3;
	logic [gaps_pkg::SLOT_W-1:0]       draw4;
	logic [gaps_pkg::SLOT_W-1:0]       draw5;
	logic [gaps_pkg::SLOT_W-1:0]       draw6;
	logic [gaps_pkg::SLOT_W-1:0]       draw7;

	modport source (output valid, mode, slot, fitness_value, uniform,
		draw0, draw1, draw2, draw3, draw4, draw5, draw6, draw7, input ready);
	modport sink (input valid, mode, slot, fitness_value, uniform,
		draw0, draw1, draw2, draw3, draw4, draw5, draw6, draw7, output ready);
endinterface

interface gaps_result_if;
	logic                        valid;
	logic                        ready;
	logic [gaps_pkg::SLOT_W-1:0] selected_slot;
	logic                        used_fallback;

	modport source (output valid, selected_slot, used_fallback, input ready);
	modport sink (input valid, selected_slot, used_fallback, output ready);
endinterface

// ===== design/ga_parent_selection_core.sv =====
// Parent selection for a genetic algorithm.
// item channel (valid/ready): mode 0 loads fitness_value into slot and
// returns nothing; mode 1 requests one parent and returns one
// transaction on the result channel (selected_slot, used_fallback).
// Configuration: cfg_we with cfg_index 0..3 writes method, minimize,
// tournament size and population size; write only while idle.
// Steps of a select, n = population in use, k = tournament size:
//   tournament  reads the k drawn slots
//   roulette    two scans, 32-step shift-add multiply, scan (a total that is not positive falls back to draw 0)
//   rank        a position scan and a rank RAM read, after a rebuild of the rank
//               order when a load or register write has marked it stale
// All fitness scans read one fitness RAM port, one slot per cycle; the rank position scan reads no RAM.
// One select is in work at a time; loads and selects are taken whenever
// the sequencer is idle, even while a result waits in the output register.
// A stalled receiver holds the result; the next select finishes and then
// waits until that register frees.
// Reset restores register defaults and marks the rank order stale; fitness
// contents are undefined until loaded.
module ga_parent_selection_core #(
	parameter int POP_MAX   = gaps_pkg::POP_MAX_DEF,
	parameter int MAX_DRAWS = gaps_pkg::MAX_DRAWS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	gaps_item_if.sink                       item,
	gaps_result_if.source                   result,
	input  logic                            cfg_we,
	input  logic [gaps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gaps_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import gaps_pkg::*;

	localparam int AW   = $clog2(POP_MAX);
	localparam int NW   = $clog2(POP_MAX + 1);
	localparam int KW   = $clog2(MAX_DRAWS + 1);
	localparam int CNTW = (NW > 6) ? NW : 6;

	cmd_t            cmd;
	sts_t            sts;
	logic [NW-1:0]   n;
	logic [KW-1:0]   k;
	logic [CNTW-1:0] idx;
	logic [AW-1:0]   i_idx;

	gaps_ctl #(.POP_MAX(POP_MAX), .MAX_DRAWS(MAX_DRAWS)) u_ctl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.n      (n),
		.k      (k),
		.cmd    (cmd),
		.idx    (idx),
		.i_idx  (i_idx)
	);

	gaps_dp #(.POP_MAX(POP_MAX), .MAX_DRAWS(MAX_DRAWS)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.result    (result),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.idx       (idx),
		.i_idx     (i_idx),
		.sts       (sts),
		.n         (n),
		.k         (k)
	);

endmodule

// ===== design/gaps_ram.sv =====
module gaps_ram #(
	parameter int W = 32,
	parameter int D = 64,
	localparam int AW = $clog2(D)
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [W-1:0]  wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [W-1:0]  rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/gaps_dp.sv =====
module gaps_dp #(
	parameter int POP_MAX   = gaps_pkg::POP_MAX_DEF,
	parameter int MAX_DRAWS = gaps_pkg::MAX_DRAWS_DEF,
	localparam int AW   = $clog2(POP_MAX),
	localparam int NW   = $clog2(POP_MAX + 1),
	localparam int KW   = $clog2(MAX_DRAWS + 1),
	localparam int CNTW = (NW > 6) ? NW : 6
) (
	input  logic                              clk,
	input  logic                              arst_n,
	gaps_item_if.sink                         item,
	gaps_result_if.source                     result,
	input  logic                              cfg_we,
	input  logic [gaps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [gaps_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	input  gaps_pkg::cmd_t                    cmd,
	input  logic [CNTW-1:0]                   idx,
	input  logic [AW-1:0]                     i_idx,
	output gaps_pkg::sts_t                    sts,
	output logic [NW-1:0]                     n,
	output logic [KW-1:0]                     k
);
	import gaps_pkg::*;

	localparam int SUM_W = 34 + AW;
	localparam int PW    = 32 + SUM_W;
	localparam int TW    = 2 * NW;
	localparam int GW    = 32 + TW;
	localparam int DIW   = (MAX_DRAWS > 1) ? $clog2(MAX_DRAWS) : 1;

	logic [1:0]  method_q;
	logic        minimize_q;
	logic [3:0]  tsize_q;
	logic [6:0]  pop_q;
	logic        stale_q;

	logic [NW-1:0] n_m1;
	logic          accept;
	logic          load_we;

	logic [SLOT_W-1:0] d_all [8];
	logic [AW-1:0]     draw_q [MAX_DRAWS];
	logic [UNI_W-1:0]  u_q;

	logic [AW-1:0]    f_raddr;
	logic             f_re;
	logic [FIT_W-1:0] f_rdata;
	logic signed [FIT_W-1:0] fq;

	logic [2:0]      op_s1;
	logic [CNTW-1:0] idx_s1;
	logic [AW-1:0]   addr_s1;

	logic signed [FIT_W-1:0] best_q;
	logic signed [FIT_W-1:0] worst_q;
	logic signed [33:0]      offset_q;
	logic signed [FIT_W-1:0] fi_q;
	logic signed [SUM_W-1:0] weight;
	logic signed [SUM_W-1:0] total_q;
	logic signed [SUM_W-1:0] cum_q;
	logic signed [SUM_W-1:0] ncum;
	logic [PW-1:0]           acc_q;
	logic [SUM_W-1:0]        r_val;
	logic                    cum_hit;
	logic                    found_q;
	logic [AW-1:0]           pos_q;
	logic                    cnt_bit;

	logic [TW-1:0] rtot_q;
	logic [GW-1:0] tgt_q;
	logic [TW-1:0] ck_q;
	logic [TW-1:0] kcum;
	logic          k_hit;

	logic [AW-1:0] rk_rdata;
	logic          rk_re;

	logic [AW-1:0] sel_q;
	logic          fb_q;
	logic          out_v_q;
	logic [SLOT_W-1:0] out_slot_q;
	logic          out_fb_q;

	function automatic logic better(input logic signed [FIT_W-1:0] a,
		input logic signed [FIT_W-1:0] b, input logic mn);
		return mn ? (a < b) : (a > b);
	endfunction

	function automatic logic [AW-1:0] clampd(input logic [SLOT_W-1:0] d,
		input logic [NW-1:0] nm1);
		if (32'(d) > 32'(nm1)) begin
			return AW'(nm1);
		end
		return AW'(d);
	endfunction

	always_comb begin
		if (pop_q < 7'd4) begin
			n = NW'(4);
		end else if (32'(pop_q) > POP_MAX) begin
			n = NW'(POP_MAX);
		end else begin
			n = NW'(pop_q);
		end
		if (tsize_q == 4'd0) begin
			k = KW'(1);
		end else if (32'(tsize_q) > MAX_DRAWS) begin
			k = KW'(MAX_DRAWS);
		end else begin
			k = KW'(tsize_q);
		end
	end
	assign n_m1 = n - NW'(1);

	assign item.ready = cmd.idle;
	assign accept     = item.valid && item.ready;
	assign load_we    = accept && !item.mode && (32'(item.slot) < POP_MAX);

	assign d_all[0] = item.draw0;
	assign d_all[1] = item.draw1;
	assign d_all[2] = item.draw2;
	assign d_all[3] = item.draw3;
	assign d_all[4] = item.draw4;
	assign d_all[5] = item.draw5;
	assign d_all[6] = item.draw6;
	assign d_all[7] = item.draw7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			method_q   <= METHOD_TOUR;
			minimize_q <= 1'b1;
			tsize_q    <= 4'd3;
			pop_q      <= 7'd50;
			stale_q    <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_METHOD:   method_q   <= cfg_wdata[1:0];
					REG_MINIMIZE: minimize_q <= cfg_wdata[0];
					REG_TOUR:     tsize_q    <= cfg_wdata[3:0];
					REG_POP:      pop_q      <= cfg_wdata[6:0];
					default: ;
				endcase
			end
			if (cmd.clr_stale) begin
				stale_q <= 1'b0;
			end
			if (load_we || (cfg_we && cfg_index inside {[REG_METHOD:REG_POP]})) begin
				stale_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.mode) begin
			for (int t = 0; t < MAX_DRAWS; t++) begin
				draw_q[t] <= clampd(d_all[t], n_m1);
			end
			u_q <= item.uniform;
		end
	end

	always_comb begin
		case (cmd.asel)
			ASEL_DRAW: f_raddr = draw_q[idx[DIW-1:0]];
			ASEL_I:    f_raddr = i_idx;
			default:   f_raddr = AW'(idx);
		endcase
	end
	assign f_re = (cmd.op != OP_NONE) && (cmd.op != OP_RANK);

	gaps_ram #(.W(FIT_W), .D(POP_MAX)) u_fit_ram (
		.clk   (clk),
		.we    (load_we),
		.waddr (AW'(item.slot)),
		.wdata (item.fitness_value),
		.re    (f_re),
		.raddr (f_raddr),
		.rdata (f_rdata)
	);
	assign fq = $signed(f_rdata);

	assign rk_re = (cmd.op == OP_RANK);

	gaps_ram #(.W(AW), .D(POP_MAX)) u_rank_ram (
		.clk   (clk),
		.we    (cmd.rk_wr),
		.waddr (pos_q),
		.wdata (i_idx),
		.re    (rk_re),
		.raddr (pos_q),
		.rdata (rk_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= OP_NONE;
		end else begin
			op_s1 <= cmd.op;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= idx;
		addr_s1 <= f_raddr;
	end

	assign weight  = minimize_q ? (SUM_W'(offset_q) - SUM_W'(fq)) : SUM_W'(fq);
	assign ncum    = ((idx_s1 == '0) ? '0 : cum_q) + weight;
	assign r_val   = acc_q[PW-1:32];
	assign cum_hit = ncum >= $signed(r_val);
	assign cnt_bit = better(fq, fi_q, minimize_q) ||
		((fq == fi_q) && (32'(addr_s1) < 32'(i_idx)));

	assign kcum  = ((idx == '0) ? '0 : ck_q) + (TW'(n) - TW'(idx));
	assign k_hit = ({kcum, 32'b0} >= tgt_q) || (32'(idx) == 32'(n_m1));

	always_ff @(posedge clk) begin
		if (accept && item.mode) begin
			fb_q <= 1'b0;
		end
		case (op_s1)
			OP_TOUR: begin
				if (idx_s1 == '0 || better(fq, best_q, minimize_q)) begin
					best_q <= fq;
					sel_q  <= addr_s1;
				end
			end
			OP_WORST: begin
				if (idx_s1 == '0 || !better(fq, worst_q, minimize_q)) begin
					worst_q  <= fq;
					offset_q <= 34'(fq) + 34'sd65536;
				end
			end
			OP_TOTAL: begin
				total_q <= ((idx_s1 == '0) ? '0 : total_q) + weight;
			end
			OP_CUM: begin
				cum_q <= ncum;
				if ((idx_s1 == '0 || !found_q) && cum_hit) begin
					sel_q <= addr_s1;
				end
				found_q <= (idx_s1 == '0) ? cum_hit : (found_q | cum_hit);
			end
			OP_FI: begin
				fi_q <= fq;
			end
			OP_CNT: begin
				pos_q <= ((idx_s1 == '0) ? '0 : pos_q) + AW'(cnt_bit);
			end
			OP_RANK: begin
				sel_q <= rk_rdata;
			end
			default: ;
		endcase
		if (cmd.chk) begin
			if (total_q > 0) begin
				sel_q <= AW'(n_m1);
			end else begin
				sel_q <= draw_q[0];
				fb_q  <= 1'b1;
			end
		end
		if (cmd.mul_clr) begin
			acc_q <= '0;
		end else if (cmd.mul_step) begin
			acc_q <= (acc_q << 1) + (u_q[~idx[4:0]] ? PW'($unsigned(total_q)) : '0);
		end
		if (cmd.rk_tot) begin
			rtot_q <= (TW'(n) * (TW'(n) + TW'(1))) >> 1;
		end
		if (cmd.rk_tgt) begin
			tgt_q <= GW'(u_q) * GW'(rtot_q);
		end
		if (cmd.scan) begin
			ck_q <= kcum;
			if (k_hit) begin
				pos_q <= AW'(idx);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (cmd.emit) begin
			out_v_q <= 1'b1;
		end else if (result.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_slot_q <= SLOT_W'(sel_q);
			out_fb_q   <= fb_q;
		end
	end

	assign result.valid         = out_v_q;
	assign result.selected_slot = out_slot_q;
	assign result.used_fallback = out_fb_q;

	assign sts.sel_start = accept && item.mode;
	assign sts.stale     = stale_q;
	assign sts.method    = method_q;
	assign sts.tot_pos   = total_q > 0;
	assign sts.hit       = k_hit;
	assign sts.out_busy  = out_v_q && !result.ready;

`ifndef SYNTHESIS
	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> !(out_v_q && !result.ready))
		else $error("result emitted over a pending transaction");
	a_rank_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == OP_RANK) |-> !stale_q)
		else $error("rank order read while stale");
	a_fallback_roul: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && fb_q |-> method_q == METHOD_ROUL)
		else $error("fallback flagged outside roulette");
`endif

endmodule

// ===== design/gaps_ctl.sv =====
module gaps_ctl #(
	parameter int POP_MAX   = gaps_pkg::POP_MAX_DEF,
	parameter int MAX_DRAWS = gaps_pkg::MAX_DRAWS_DEF,
	localparam int AW   = $clog2(POP_MAX),
	localparam int NW   = $clog2(POP_MAX + 1),
	localparam int KW   = $clog2(MAX_DRAWS + 1),
	localparam int CNTW = (NW > 6) ? NW : 6
) (
	input  logic            clk,
	input  logic            arst_n,
	input  gaps_pkg::sts_t  sts,
	input  logic [NW-1:0]   n,
	input  logic [KW-1:0]   k,
	output gaps_pkg::cmd_t  cmd,
	output logic [CNTW-1:0] idx,
	output logic [AW-1:0]   i_idx
);
	import gaps_pkg::*;

	localparam logic [4:0] S_IDLE  = 5'd0;
	localparam logic [4:0] S_T_RD  = 5'd1;
	localparam logic [4:0] S_T_DR  = 5'd2;
	localparam logic [4:0] S_W_RD  = 5'd3;
	localparam logic [4:0] S_W_DR  = 5'd4;
	localparam logic [4:0] S_S_RD  = 5'd5;
	localparam logic [4:0] S_S_DR  = 5'd6;
	localparam logic [4:0] S_CHK   = 5'd7;
	localparam logic [4:0] S_MUL   = 5'd8;
	localparam logic [4:0] S_C_RD  = 5'd9;
	localparam logic [4:0] S_C_DR  = 5'd10;
	localparam logic [4:0] S_B_FI  = 5'd11;
	localparam logic [4:0] S_B_FW  = 5'd12;
	localparam logic [4:0] S_B_SW  = 5'd13;
	localparam logic [4:0] S_B_SD  = 5'd14;
	localparam logic [4:0] S_B_WR  = 5'd15;
	localparam logic [4:0] S_K_TOT = 5'd16;
	localparam logic [4:0] S_K_TGT = 5'd17;
	localparam logic [4:0] S_K_SCN = 5'd18;
	localparam logic [4:0] S_K_RD  = 5'd19;
	localparam logic [4:0] S_K_RW  = 5'd20;
	localparam logic [4:0] S_DONE  = 5'd21;

	logic [4:0]      state_q, state_d;
	logic [CNTW-1:0] idx_q, idx_d;
	logic [AW-1:0]   i_q, i_d;
	logic            idx_last;
	logic            k_last;
	logic            i_last;

	assign idx_last = 32'(idx_q) == 32'(n) - 1;
	assign k_last   = 32'(idx_q) == 32'(k) - 1;
	assign i_last   = 32'(i_q) == 32'(n) - 1;

	always_comb begin
		state_d = state_q;
		idx_d   = idx_q;
		i_d     = i_q;
		cmd     = '0;
		cmd.op  = OP_NONE;
		cmd.asel = ASEL_IDX;
		case (state_q)
			S_IDLE: begin
				cmd.idle = 1'b1;
				idx_d    = '0;
				i_d      = '0;
				if (sts.sel_start) begin
					case (sts.method)
						METHOD_ROUL: state_d = S_W_RD;
						METHOD_RANK: state_d = sts.stale ? S_B_FI : S_K_TOT;
						default:     state_d = S_T_RD;
					endcase
				end
			end
			S_T_RD: begin
				cmd.op   = OP_TOUR;
				cmd.asel = ASEL_DRAW;
				idx_d    = idx_q + 1'b1;
				if (k_last) begin
					state_d = S_T_DR;
				end
			end
			S_T_DR: state_d = S_DONE;
			S_W_RD: begin
				cmd.op = OP_WORST;
				idx_d  = idx_q + 1'b1;
				if (idx_last) begin
					state_d = S_W_DR;
				end
			end
			S_W_DR: begin
				idx_d   = '0;
				state_d = S_S_RD;
			end
			S_S_RD: begin
				cmd.op = OP_TOTAL;
				idx_d  = idx_q + 1'b1;
				if (idx_last) begin
					state_d = S_S_DR;
				end
			end
			S_S_DR: state_d = S_CHK;
			S_CHK: begin
				cmd.chk     = 1'b1;
				cmd.mul_clr = 1'b1;
				idx_d       = '0;
				state_d     = sts.tot_pos ? S_MUL : S_DONE;
			end
			S_MUL: begin
				cmd.mul_step = 1'b1;
				idx_d        = idx_q + 1'b1;
				if (idx_q == CNTW'(31)) begin
					idx_d   = '0;
					state_d = S_C_RD;
				end
			end
			S_C_RD: begin
				cmd.op = OP_CUM;
				idx_d  = idx_q + 1'b1;
				if (idx_last) begin
					state_d = S_C_DR;
				end
			end
			S_C_DR: state_d = S_DONE;
			S_B_FI: begin
				cmd.op   = OP_FI;
				cmd.asel = ASEL_I;
				state_d  = S_B_FW;
			end
			S_B_FW: begin
				idx_d   = '0;
				state_d = S_B_SW;
			end
			S_B_SW: begin
				cmd.op = OP_CNT;
				idx_d  = idx_q + 1'b1;
				if (idx_last) begin
					state_d = S_B_SD;
				end
			end
			S_B_SD: state_d = S_B_WR;
			S_B_WR: begin
				cmd.rk_wr = 1'b1;
				if (i_last) begin
					cmd.clr_stale = 1'b1;
					state_d       = S_K_TOT;
				end else begin
					i_d     = i_q + 1'b1;
					state_d = S_B_FI;
				end
			end
			S_K_TOT: begin
				cmd.rk_tot = 1'b1;
				state_d    = S_K_TGT;
			end
			S_K_TGT: begin
				cmd.rk_tgt = 1'b1;
				idx_d      = '0;
				state_d    = S_K_SCN;
			end
			S_K_SCN: begin
				cmd.scan = 1'b1;
				if (sts.hit) begin
					state_d = S_K_RD;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			S_K_RD: begin
				cmd.op  = OP_RANK;
				state_d = S_K_RW;
			end
			S_K_RW: state_d = S_DONE;
			S_DONE: begin
				if (!sts.out_busy) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			i_q     <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			i_q     <= i_d;
		end
	end

	assign idx   = idx_q;
	assign i_idx = i_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		sts.sel_start |-> state_q == S_IDLE)
		else $error("transaction accepted while busy");
	a_emit_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> state_q == S_IDLE)
		else $error("no return to idle after result");
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_K_SCN |-> 32'(idx_q) < 32'(n))
		else $error("rank scan ran past population");
`endif

endmodule

// ===== tb/ga_parent_selection_core_tb.sv =====
module ga_parent_selection_core_tb;
	import gaps_pkg::*;

	localparam logic [1:0] METHOD_SPARE = 2'd3;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
	localparam logic MODE_LOAD = 1'b0;
	localparam logic MODE_SELECT = 1'b1;
	localparam int CYCLE_LIMIT = 6000000;

	typedef struct {
		logic mode;
		logic [SLOT_W-1:0] slot;
		logic signed [FIT_W-1:0] fitness_value;
		logic [UNI_W-1:0] uniform;
		logic [SLOT_W-1:0] draws [8];
	} sel_item_t;

	typedef struct {
		logic [SLOT_W-1:0] slot;
		logic fallback;
	} parent_t;

	class selection_scoreboard;
		logic signed [FIT_W-1:0] fitness [64];
		logic [1:0] method = METHOD_TOUR;
		logic minimize = 1'b1;
		logic [3:0] tour_size = 4'd3;
		logic [6:0] pop_setting = 7'd50;
		parent_t parents_due [$];
		int errors = 0;

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				REG_METHOD: method = data[1:0];
				REG_MINIMIZE: minimize = data[0];
				REG_TOUR: tour_size = data[3:0];
				REG_POP: pop_setting = data;
				default: ;
			endcase
		endfunction

		function bit beats(longint a, longint b);
			return minimize ? (a < b) : (a > b);
		endfunction

		function parent_t pick_parent(sel_item_t it);
			parent_t p;
			int n, k, best, pos, d [8];
			longint worst, offset, total, cum, w;
			bit [63:0] ut, hi, lo, r, target, acc;
			n = (pop_setting < 4) ? 4 : ((pop_setting > 64) ? 64 : int'(pop_setting));
			for (int i = 0; i < 8; i++)
				d[i] = (it.draws[i] > n - 1) ? n - 1 : int'(it.draws[i]);
			p.fallback = 1'b0;
			if (method == METHOD_ROUL) begin
				worst = fitness[0];
				for (int i = 1; i < n; i++)
					if (!beats(fitness[i], worst)) worst = fitness[i];
				offset = minimize ? worst + 65536 : 0;
				total = 0;
				for (int i = 0; i < n; i++)
					total += minimize ? offset - fitness[i] : longint'(fitness[i]);
				if (total <= 0) begin
					p.slot = SLOT_W'(d[0]);
					p.fallback = 1'b1;
					return p;
				end
				ut = total;
				hi = (64'(it.uniform) >> 16) * ut;
				lo = (64'(it.uniform) & 64'hFFFF) * ut;
				r = (hi + (lo >> 16)) >> 16;
				cum = 0;
				p.slot = SLOT_W'(n - 1);
				for (int i = 0; i < n; i++) begin
					w = minimize ? offset - fitness[i] : longint'(fitness[i]);
					cum += w;
					if (cum >= longint'(r)) begin
						p.slot = SLOT_W'(i);
						break;
					end
				end
			end else if (method == METHOD_RANK) begin
				target = 64'(it.uniform) * 64'(n * (n + 1) / 2);
				acc = 0;
				pos = n - 1;
				for (int i = 0; i < n; i++) begin
					acc += 64'(n - i);
					if ((acc << 32) >= target) begin
						pos = i;
						break;
					end
				end
				for (int i = 0; i < n; i++) begin
					int cnt;
					cnt = 0;
					for (int j = 0; j < n; j++)
						if (beats(fitness[j], fitness[i]) ||
								(fitness[j] == fitness[i] && j < i))
							cnt++;
					if (cnt == pos) p.slot = SLOT_W'(i);
				end
			end else begin
				k = (tour_size < 1) ? 1 : ((tour_size > 8) ? 8 : int'(tour_size));
				best = d[0];
				for (int t = 1; t < k; t++)
					if (beats(fitness[d[t]], fitness[best])) best = d[t];
				p.slot = SLOT_W'(best);
			end
			return p;
		endfunction

		function void note_item(sel_item_t it);
			if (it.mode == MODE_LOAD)
				fitness[it.slot] = it.fitness_value;
			else
				parents_due.push_back(pick_parent(it));
		endfunction

		task check(logic [SLOT_W-1:0] slot, logic fallback);
			parent_t e;
			if (parents_due.size() == 0) begin
				report($sformatf("unexpected result slot %0d", slot));
				return;
			end
			e = parents_due.pop_front();
			if (slot !== e.slot)
				report($sformatf("selected_slot %0d, expected %0d", slot, e.slot));
			if (fallback !== e.fallback)
				report($sformatf("used_fallback %0b, expected %0b", fallback, e.fallback));
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;
	int cycles = 0;
	bit hold_long = 1'b0;
	selection_scoreboard sb = new();

	gaps_item_if item ();
	gaps_result_if result ();

	ga_parent_selection_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.item(item.sink),
		.result(result.sink),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task send_item(sel_item_t it, bit allow_gap);
		int gap;
		gap = allow_gap ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			item.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item.valid <= 1'b1;
		item.mode <= it.mode;
		item.slot <= it.slot;
		item.fitness_value <= it.fitness_value;
		item.uniform <= it.uniform;
		item.draw0 <= it.draws[0];
		item.draw1 <= it.draws[1];
		item.draw2 <= it.draws[2];
		item.draw3 <= it.draws[3];
		item.draw4 <= it.draws[4];
		item.draw5 <= it.draws[5];
		item.draw6 <= it.draws[6];
		item.draw7 <= it.draws[7];
		do @(posedge clk); while (!item.ready);
		sb.note_item(it);
	endtask

	task drain();
		item.valid <= 1'b0;
		while (sb.parents_due.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.write_reg(idx, data);
		@(posedge clk);
	endtask

	function logic signed [FIT_W-1:0] rand_fitness(bit neg_only);
		logic signed [FIT_W-1:0] v;
		case ($urandom_range(0, 9))
			0: v = 32'h8000_0000;
			1: v = 32'h7FFF_FFFF;
			2: v = 32'h0001_0000;
			3: v = 32'($urandom_range(0, 3) << 16);
			default: v = $urandom;
		endcase
		if (neg_only) v[31] = 1'b1;
		return v;
	endfunction

	function sel_item_t make_item(bit is_load, bit neg_only);
		sel_item_t it;
		it.mode = is_load ? MODE_LOAD : MODE_SELECT;
		it.slot = SLOT_W'($urandom);
		it.fitness_value = rand_fitness(neg_only);
		case ($urandom_range(0, 5))
			0: it.uniform = 32'h0;
			1: it.uniform = 32'hFFFF_FFFF;
			default: it.uniform = $urandom;
		endcase
		for (int i = 0; i < 8; i++) it.draws[i] = SLOT_W'($urandom);
		return it;
	endfunction

	task run_phase(logic [1:0] method, logic minimize, logic [3:0] tsize, logic [6:0] pop,
			int count, int load_pct, bit neg_only);
		drain();
		write_reg(REG_METHOD, CFG_DATA_W'(method));
		write_reg(REG_MINIMIZE, CFG_DATA_W'(minimize));
		write_reg(REG_TOUR, CFG_DATA_W'(tsize));
		write_reg(REG_POP, pop);
		for (int i = 0; i < count; i++)
			send_item(make_item($urandom_range(0, 99) < load_pct, neg_only), $urandom_range(0, 3) != 0);
	endtask

	initial begin
		forever begin
			int stall;
			if (hold_long) begin
				result.ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_long = 1'b0;
			end
			stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				result.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			result.ready <= 1'b1;
			do @(posedge clk); while (!(result.valid && result.ready));
			sb.check(result.selected_slot, result.used_fallback);
		end
	end

	initial begin
		sel_item_t it;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		item.valid <= 1'b0;
		item.mode <= MODE_LOAD;
		item.slot <= '0;
		item.fitness_value <= '0;
		item.uniform <= '0;
		{item.draw0, item.draw1, item.draw2, item.draw3} <= '0;
		{item.draw4, item.draw5, item.draw6, item.draw7} <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill every slot, with extremes and ties up front
		for (int s = 0; s < 64; s++) begin
			it = make_item(1'b1, 1'b0);
			it.slot = SLOT_W'(s);
			if (s == 0) it.fitness_value = 32'h8000_0000;
			if (s == 1) it.fitness_value = 32'h7FFF_FFFF;
			if (s == 2 || s == 3) it.fitness_value = 32'h0002_0000;
			send_item(it, 1'b1);
		end

		// defaults from reset: tournament, minimize, k=3, n=50
		it = make_item(1'b0, 1'b0);
		for (int i = 0; i < 8; i++) it.draws[i] = 6'h3F;
		send_item(it, 1'b0);
		it.draws[0] = 6'd0;
		it.draws[1] = 6'd1;
		send_item(it, 1'b0);
		drain();
		write_reg(REG_UNUSED, 7'h7F);
		write_reg(REG_TOUR, 7'd15);
		write_reg(REG_MINIMIZE, 7'd0);
		for (int i = 0; i < 3; i++) send_item(make_item(1'b0, 1'b0), 1'b0);
		run_phase(METHOD_TOUR, 1'b1, 4'd0, 7'd0, 3, 0, 1'b0);
		run_phase(METHOD_SPARE, 1'b0, 4'd8, 7'd127, 3, 0, 1'b0);
		run_phase(METHOD_ROUL, 1'b1, 4'd3, 7'd4, 4, 0, 1'b0);
		run_phase(METHOD_ROUL, 1'b0, 4'd3, 7'd64, 3, 0, 1'b0);
		run_phase(METHOD_RANK, 1'b1, 4'd3, 7'd4, 3, 0, 1'b0);
		run_phase(METHOD_RANK, 1'b0, 4'd3, 7'd64, 3, 0, 1'b0);

		// negative fitness loads under maximize drive roulette toward the fallback path
		run_phase(METHOD_ROUL, 1'b0, 4'd3, 7'd8, 30, 40, 1'b1);

		// long receiver hold while the sender keeps pushing selects
		drain();
		hold_long = 1'b1;
		run_phase(METHOD_TOUR, 1'b1, 4'd5, 7'd16, 30, 10, 1'b0);

		for (int p = 0; p < 16; p++) begin
			logic [6:0] pop;
			pop = ($urandom_range(0, 5) == 0) ? 7'($urandom_range(17, 127))
				: 7'($urandom_range(0, 16));
			run_phase(2'($urandom_range(0, 3)), 1'($urandom), 4'($urandom_range(0, 15)), pop,
				(pop > 16) ? 10 : 22, 30, 1'b0);
		end

		drain();
		repeat (300) @(posedge clk);
		if (sb.errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
